[sv/tsd_pkg.sv]
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared widths, register indexes and reset values of the tile deviation core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsd_pkg;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W     = 16;
  localparam int SD_W      = 24;
  localparam int TIDX_W    = 7;
  localparam int FRAC_BITS = 8;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] CFG_SIZE_RST = 11'd1024;

endpackage

[sv/tsd_if.sv]
// ----------------------------------------------------------------------------
// tsd_if
// Valid/ready channels: pixel words in, tile deviation words out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsd_pixel_if;
  import tsd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface tsd_result_if;
  import tsd_pkg::*;

  logic              valid;
  logic              ready;
  logic [SD_W-1:0]   std_dev;
  logic [TIDX_W-1:0] tile_row;
  logic [TIDX_W-1:0] tile_col;
  logic              last_tile;

  modport source (output valid, output std_dev, output tile_row, output tile_col,
                  output last_tile, input ready);
  modport sink   (input valid, input std_dev, input tile_row, input tile_col,
                  input last_tile, output ready);
endinterface

[sv/tile_std_deviation_core.sv]
// ----------------------------------------------------------------------------
// tile_std_deviation_core
// Per-tile standard deviation over a raster stream of signed coefficients.
// Pixel words enter on pix_i in raster order; one result word leaves on res_o
// for every tile whose last pixel arrives (std_dev with 8 fraction bits, tile
// row and column, last-tile flag). Image size comes from cfg registers 0 and 1;
// a write to either restarts the image at pixel (0,0).
// Per-column sums live in one memory (one entry per tile column), read when a
// pixel is taken and written back the next cycle.
// Each pixel passes through read and update; no new pixel is taken before it
// is done. A tile-finishing pixel goes on through square, difference, the
// bit-per-cycle square root, then the load of the output register.
// The output register holds a result while the receiver stalls; the next pixel
// is taken meanwhile, and only a second result waits for the slot.
// Reset restores a 1024 x 1024 image, clears positions and empties the output.
// The memory needs no clearing: a tile's first pixel overwrites its entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tile_std_deviation_core #(
  parameter int TILE_SIZE  = 8,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tsd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tsd_pkg::CFG_W-1:0]     cfg_data_i,
  tsd_pixel_if.sink                     pix_i,
  tsd_result_if.source                  res_o
);
  import tsd_pkg::*;

  localparam int TILE_AREA = TILE_SIZE * TILE_SIZE;
  localparam int TILE_COLS = (MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
  localparam int TILE_ROWS = (MAX_HEIGHT + TILE_SIZE - 1) / TILE_SIZE;
  localparam int CT_W      = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
  localparam int RT_W      = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
  localparam int SUB_W     = $clog2(TILE_SIZE);
  localparam int CPOS_W    = $clog2(MAX_WIDTH);
  localparam int RPOS_W    = $clog2(MAX_HEIGHT);
  localparam int CCMP_W    = (CFG_W > CPOS_W + 1) ? CFG_W : CPOS_W + 1;
  localparam int RCMP_W    = (CFG_W > RPOS_W + 1) ? CFG_W : RPOS_W + 1;
  localparam int AREA_W    = $clog2(TILE_AREA + 1);
  localparam int SUM_W     = PIX_W + $clog2(TILE_AREA);
  localparam int SQ_W      = 2 * PIX_W - 1 + $clog2(TILE_AREA);
  localparam int PROD_W    = SQ_W + AREA_W;
  localparam int MEM_W     = SUM_W + SQ_W;
  localparam int AREA_SQ   = TILE_AREA * TILE_AREA;
  localparam int ASQ_W     = $clog2(AREA_SQ + 1);
  localparam int REM_W     = ASQ_W + 28;
  localparam int XS_W      = 2 * SD_W;
  localparam int XS_SH     = 2 * FRAC_BITS;
  localparam int HI_SH     = XS_W - XS_SH;
  localparam int CNT_W     = $clog2(SD_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_SQR,
    ST_DIFF,
    ST_ROOT,
    ST_OUT
  } state_e;

  state_e state_q;

  logic [CFG_W-1:0]  width_q, height_q;
  logic [CPOS_W-1:0] col_pos_q;
  logic [RPOS_W-1:0] row_pos_q;
  logic [SUB_W-1:0]  col_sub_q, row_sub_q;
  logic [CT_W-1:0]   col_tile_q;
  logic [RT_W-1:0]   row_tile_q;

  logic [CCMP_W-1:0] w_cmp, w_eff;
  logic [RCMP_W-1:0] h_cmp, h_eff;
  logic [CPOS_W-1:0] w_last;
  logic [RPOS_W-1:0] h_last;
  logic              col_end, row_end, col_sub_end, row_sub_end, accept;

  logic                    first_q, tile_end_q, last_q;
  logic [CT_W-1:0]         tcol_q;
  logic [RT_W-1:0]         trow_q;
  logic signed [PIX_W-1:0] v_q;
  logic [2*PIX_W-2:0]      vsq_q;
  logic [MEM_W-1:0]        mem [TILE_COLS];
  logic [MEM_W-1:0]        rd_q;

  logic signed [2*PIX_W-1:0] vsq_full;
  logic signed [SUM_W-1:0]   rd_sum, new_sum, s_q;
  logic [SQ_W-1:0]           rd_sq, new_sq, ss_q;
  logic signed [2*SUM_W-1:0] sq_full;
  logic [PROD_W-1:0]         sq_q, nss, dpos;
  logic signed [PROD_W:0]    diff;

  logic [REM_W-1:0] rem_q, p_q, rem4, trial;
  logic             take;
  logic [XS_W-1:0]  xs_q;
  logic [SD_W-1:0]  q_q;
  logic [CNT_W-1:0] cnt_q;

  logic              out_valid_q, out_last_q, out_load;
  logic [SD_W-1:0]   out_sd_q;
  logic [TIDX_W-1:0] out_row_q, out_col_q;

  always_comb begin
    w_cmp = CCMP_W'(width_q);
    h_cmp = RCMP_W'(height_q);
    if (width_q == '0) begin
      w_eff = CCMP_W'(1);
    end else if (w_cmp > CCMP_W'(MAX_WIDTH)) begin
      w_eff = CCMP_W'(MAX_WIDTH);
    end else begin
      w_eff = w_cmp;
    end
    if (height_q == '0) begin
      h_eff = RCMP_W'(1);
    end else if (h_cmp > RCMP_W'(MAX_HEIGHT)) begin
      h_eff = RCMP_W'(MAX_HEIGHT);
    end else begin
      h_eff = h_cmp;
    end
    w_last = CPOS_W'(w_eff - CCMP_W'(1));
    h_last = RPOS_W'(h_eff - RCMP_W'(1));
  end

  assign col_end     = (col_pos_q == w_last);
  assign row_end     = (row_pos_q == h_last);
  assign col_sub_end = (col_sub_q == SUB_W'(TILE_SIZE - 1));
  assign row_sub_end = (row_sub_q == SUB_W'(TILE_SIZE - 1));

  assign pix_i.ready = (state_q == ST_IDLE);
  assign accept      = pix_i.valid & pix_i.ready;

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || res_o.ready);

  assign vsq_full = pix_i.pixel * pix_i.pixel;
  assign rd_sum   = rd_q[MEM_W-1:SQ_W];
  assign rd_sq    = rd_q[SQ_W-1:0];
  assign new_sum  = (first_q ? SUM_W'(0) : rd_sum) + {{(SUM_W-PIX_W){v_q[PIX_W-1]}}, v_q};
  assign new_sq   = (first_q ? SQ_W'(0) : rd_sq) + SQ_W'(vsq_q);

  assign sq_full = s_q * s_q;
  assign nss     = PROD_W'(ss_q) * PROD_W'(TILE_AREA);
  assign diff    = $signed({1'b0, nss}) - $signed({1'b0, sq_q});
  assign dpos    = diff[PROD_W] ? '0 : diff[PROD_W-1:0];

  assign rem4  = {rem_q[REM_W-3:0], xs_q[XS_W-1:XS_W-2]};
  assign trial = {p_q[REM_W-3:0], 2'b00} + REM_W'(AREA_SQ);
  assign take  = (rem4 >= trial);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPD) begin
      mem[tcol_q] <= {new_sum, new_sq};
    end
    if (accept) begin
      rd_q <= mem[col_tile_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      v_q        <= pix_i.pixel;
      vsq_q      <= vsq_full[2*PIX_W-2:0];
      first_q    <= (col_sub_q == '0) && (row_sub_q == '0);
      tile_end_q <= (col_sub_end || col_end) && (row_sub_end || row_end);
      last_q     <= col_end && row_end;
      tcol_q     <= col_tile_q;
      trow_q     <= row_tile_q;
    end
    unique case (state_q)
      ST_UPD: begin
        s_q  <= new_sum;
        ss_q <= new_sq;
      end
      ST_SQR: begin
        sq_q <= PROD_W'(sq_full);
      end
      ST_DIFF: begin
        rem_q <= REM_W'(dpos >> HI_SH);
        xs_q  <= {dpos[HI_SH-1:0], XS_SH'(0)};
        p_q   <= '0;
        q_q   <= '0;
      end
      ST_ROOT: begin
        rem_q <= take ? rem4 - trial : rem4;
        p_q   <= take ? {p_q[REM_W-2:0], 1'b0} + REM_W'(AREA_SQ) : {p_q[REM_W-2:0], 1'b0};
        q_q   <= {q_q[SD_W-2:0], take};
        xs_q  <= {xs_q[XS_W-3:0], 2'b00};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= CFG_SIZE_RST;
      height_q    <= CFG_SIZE_RST;
      col_pos_q   <= '0;
      row_pos_q   <= '0;
      col_sub_q   <= '0;
      row_sub_q   <= '0;
      col_tile_q  <= '0;
      row_tile_q  <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_sd_q    <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i && (cfg_idx_i == REG_IMAGE_WIDTH || cfg_idx_i == REG_IMAGE_HEIGHT)) begin
        if (cfg_idx_i == REG_IMAGE_WIDTH) begin
          width_q <= cfg_data_i;
        end else begin
          height_q <= cfg_data_i;
        end
        col_pos_q  <= '0;
        row_pos_q  <= '0;
        col_sub_q  <= '0;
        row_sub_q  <= '0;
        col_tile_q <= '0;
        row_tile_q <= '0;
      end else if (accept) begin
        if (col_end) begin
          col_pos_q  <= '0;
          col_sub_q  <= '0;
          col_tile_q <= '0;
          if (row_end) begin
            row_pos_q  <= '0;
            row_sub_q  <= '0;
            row_tile_q <= '0;
          end else begin
            row_pos_q <= row_pos_q + RPOS_W'(1);
            row_sub_q <= row_sub_end ? '0 : row_sub_q + SUB_W'(1);
            if (row_sub_end) begin
              row_tile_q <= row_tile_q + RT_W'(1);
            end
          end
        end else begin
          col_pos_q <= col_pos_q + CPOS_W'(1);
          col_sub_q <= col_sub_end ? '0 : col_sub_q + SUB_W'(1);
          if (col_sub_end) begin
            col_tile_q <= col_tile_q + CT_W'(1);
          end
        end
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          state_q <= tile_end_q ? ST_SQR : ST_IDLE;
        end
        ST_SQR: begin
          state_q <= ST_DIFF;
        end
        ST_DIFF: begin
          cnt_q   <= '0;
          state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(SD_W - 1)) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_sd_q    <= q_q;
            out_row_q   <= TIDX_W'(trow_q);
            out_col_q   <= TIDX_W'(tcol_q);
            out_last_q  <= last_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.std_dev   = out_sd_q;
  assign res_o.tile_row  = out_row_q;
  assign res_o.tile_col  = out_col_q;
  assign res_o.last_tile = out_last_q;

endmodule

[sv/tsd_checker.sv]
// ----------------------------------------------------------------------------
// tsd_checker
// Port-level checks of the tile deviation core, bound to tile_std_deviation_core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsd_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [tsd_pkg::SD_W-1:0]   std_dev_i,
  input logic [tsd_pkg::TIDX_W-1:0] tile_row_i,
  input logic [tsd_pkg::TIDX_W-1:0] tile_col_i,
  input logic                      last_tile_i
);
  import tsd_pkg::*;

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result word valid during reset");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("pixel word taken on two consecutive cycles");

  a_load_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result word appeared without a pixel in flight");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(std_dev_i) &&
      $stable(tile_row_i) && $stable(tile_col_i) && $stable(last_tile_i))
    else $error("stalled result word changed");

endmodule

bind tile_std_deviation_core tsd_checker u_tsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .std_dev_i   (res_o.std_dev),
  .tile_row_i  (res_o.tile_row),
  .tile_col_i  (res_o.tile_col),
  .last_tile_i (res_o.last_tile)
);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for tile_std_deviation_core. A scoreboard class mirrors
// the per-column tile sums and predicts one deviation word per finished tile;
// plain tasks stream pixel words and program the image size. Covers single
// pixel images, partial edge tiles, clamped sizes, writes to unused register
// slots, a full-width image and random sizes and data, with random gaps on
// both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import tsd_pkg::*;

  localparam int TILE          = 8;
  localparam int MAX_DIM       = 1024;
  localparam int TILE_COLS     = MAX_DIM / TILE;
  localparam int RANDOM_PIXELS = 250;
  localparam int SETTLE_CYCLES = 32;
  localparam int STALL_LIMIT   = 2000;
  localparam int REPORT_LIMIT  = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum int {DATA_FULL, DATA_SMALL, DATA_RAILS, DATA_FLAT, DATA_SPARSE} data_mode_e;

  typedef struct packed {
    logic [SD_W-1:0]   std_dev;
    logic [TIDX_W-1:0] tile_row;
    logic [TIDX_W-1:0] tile_col;
    logic              last_tile;
  } tile_word_t;

  class tile_dev_board;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    int unsigned      col_pos;
    int unsigned      row_pos;
    longint           band_sum[TILE_COLS];
    longint           band_sq_sum[TILE_COLS];
    tile_word_t       pending_q[$];
    int               errors;
    int               words_checked;
    int               last_tiles;
    int               max_row;
    int               max_col;
    logic [SD_W-1:0]  max_dev;

    function new();
      width_reg     = CFG_SIZE_RST;
      height_reg    = CFG_SIZE_RST;
      col_pos       = 0;
      row_pos       = 0;
      errors        = 0;
      words_checked = 0;
      last_tiles    = 0;
      max_row       = 0;
      max_col       = 0;
      max_dev       = '0;
    endfunction

    function int unsigned eff_size(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_IMAGE_WIDTH: width_reg = v;
        REG_IMAGE_HEIGHT: height_reg = v;
        default: return;
      endcase
      col_pos = 0;
      row_pos = 0;
    endfunction

    // largest q with (64*q)^2 <= 65536*d
    function logic [SD_W-1:0] scaled_root(longint unsigned d);
      longint unsigned target;
      longint unsigned q;
      longint unsigned t;
      longint unsigned m;
      target = d << 16;
      q = 0;
      for (int b = SD_W - 1; b >= 0; b--) begin
        t = q | (64'd1 << b);
        m = t * (TILE * TILE);
        if (m * m <= target) q = t;
      end
      return SD_W'(q);
    endfunction

    function void note_pixel(logic signed [PIX_W-1:0] p);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      int unsigned idx;
      longint      v;
      longint      s;
      longint      d;
      tile_word_t  word;
      w = eff_size(width_reg);
      h = eff_size(height_reg);
      c = (col_pos >= w) ? 0 : col_pos;
      r = (row_pos >= h) ? 0 : row_pos;
      idx = c / TILE;
      v = p;
      if (r % TILE == 0 && c % TILE == 0) begin
        band_sum[idx] = v;
        band_sq_sum[idx] = v * v;
      end else begin
        band_sum[idx] += v;
        band_sq_sum[idx] += v * v;
      end
      if ((c % TILE == TILE - 1 || c == w - 1) && (r % TILE == TILE - 1 || r == h - 1)) begin
        s = band_sum[idx];
        d = TILE * TILE * band_sq_sum[idx] - s * s;
        word.std_dev   = scaled_root((d > 0) ? d : 0);
        word.tile_row  = TIDX_W'(r / TILE);
        word.tile_col  = TIDX_W'(c / TILE);
        word.last_tile = (c == w - 1 && r == h - 1);
        pending_q.insert(pending_q.size(), word);
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
    endfunction

    function void check_result(tile_word_t got);
      tile_word_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected tile word: sd=%0d row=%0d col=%0d last=%0b",
                   got.std_dev, got.tile_row, got.tile_col, got.last_tile);
        return;
      end
      want = pending_q.pop_front();
      words_checked++;
      if (want.last_tile) last_tiles++;
      if (want.tile_row > max_row) max_row = want.tile_row;
      if (want.tile_col > max_col) max_col = want.tile_col;
      if (want.std_dev > max_dev) max_dev = want.std_dev;
      if (got.std_dev !== want.std_dev || got.tile_row !== want.tile_row ||
          got.tile_col !== want.tile_col || got.last_tile !== want.last_tile) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("tile word %0d mismatch:", words_checked,
                   " expected sd=%0d row=%0d col=%0d last=%0b,",
                   want.std_dev, want.tile_row, want.tile_col, want.last_tile,
                   " got sd=%0d row=%0d col=%0d last=%0b",
                   got.std_dev, got.tile_row, got.tile_col, got.last_tile);
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  tsd_pixel_if  pix ();
  tsd_result_if res ();

  tile_std_deviation_core #(
    .TILE_SIZE (TILE),
    .MAX_WIDTH (MAX_DIM),
    .MAX_HEIGHT(MAX_DIM)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .pix_i     (pix),
    .res_o     (res)
  );

  tile_dev_board board = new();
  bit            send_idle_on = 1'b1;
  bit            recv_idle_on = 1'b1;
  int            quiet_cycles = 0;
  int            pixels_sent  = 0;
  int            random_sent  = 0;
  int            phases_run   = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic int draw_gap(bit on);
    return on ? $urandom_range(0, 19) : 0;
  endfunction

  function automatic logic signed [PIX_W-1:0] draw_pixel(data_mode_e mode,
                                                         logic signed [PIX_W-1:0] level);
    int k;
    k = $urandom_range(0, 32);
    case (mode)
      DATA_FULL: return PIX_W'($urandom);
      DATA_SMALL: return PIX_W'(k - 16);
      DATA_RAILS: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      DATA_FLAT: return level;
      default: return ($urandom_range(0, 7) == 0) ? PIX_W'($urandom) : '0;
    endcase
  endfunction

  task automatic send_pixel(logic signed [PIX_W-1:0] p);
    int gap;
    gap = draw_gap(send_idle_on);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.pixel <= p;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    board.note_pixel(p);
    pixels_sent++;
  endtask

  // hold the pixel stream until every tile word is back
  task automatic drain();
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() > 0) @(posedge clk_i);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    board.write_reg(idx, v);
  endtask

  task automatic stream_pixels(int unsigned n, data_mode_e mode, bit pauses);
    logic signed [PIX_W-1:0] level;
    level = PIX_W'($urandom);
    for (int i = 0; i < n; i++) begin
      if (pauses && $urandom_range(0, 59) == 0) drain();
      send_pixel(draw_pixel(mode, level));
    end
    settle();
    phases_run++;
  endtask

  task automatic random_phase();
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    int unsigned      pick;
    int unsigned      area;
    int unsigned      n;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      w = CFG_W'($urandom_range(1, 24));
      h = CFG_W'($urandom_range(1, 24));
    end else if (pick == 6) begin
      w = '0;
      h = CFG_W'($urandom_range(0, 20));
    end else if (pick == 7) begin
      w = CFG_W'($urandom_range(1, 20));
      h = '0;
    end else if (pick == 8) begin
      w = CFG_W'($urandom_range(25, 200));
      h = CFG_W'($urandom_range(1, 3));
    end else begin
      w = CFG_W'($urandom_range(0, 2));
      h = CFG_W'($urandom_range(MAX_DIM + 1, (1 << CFG_W) - 1));
    end
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      write_cfg(REG_IMAGE_WIDTH, w);
      write_cfg(REG_IMAGE_HEIGHT, h);
    end else if (pick < 8) begin
      write_cfg(REG_IMAGE_HEIGHT, h);
      write_cfg(REG_IMAGE_WIDTH, w);
    end else if (pick == 8) begin
      write_cfg(REG_IMAGE_WIDTH, w);
    end else begin
      write_cfg(REG_IMAGE_HEIGHT, h);
    end
    if ($urandom_range(0, 5) == 0)
      write_cfg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
    area = board.eff_size(board.width_reg) * board.eff_size(board.height_reg);
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, area);
    end else begin
      n = area * $urandom_range(1, 2) + $urandom_range(0, board.eff_size(board.width_reg));
    end
    if (n > 120) n = 120;
    send_idle_on = ($urandom_range(0, 3) != 0);
    recv_idle_on = ($urandom_range(0, 3) != 0);
    stream_pixels(n, data_mode_e'($urandom_range(0, 4)), 1'b1);
    random_sent += n;
  endtask

  initial begin
    tile_word_t got;
    int         stall;
    res.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_gap(recv_idle_on);
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      @(posedge clk_i);
      while (!res.valid) @(posedge clk_i);
      got.std_dev   = res.std_dev;
      got.tile_row  = res.tile_row;
      got.tile_col  = res.tile_col;
      got.last_tile = res.last_tile;
      board.check_result(got);
    end
  end

  initial begin
    logic signed [PIX_W-1:0] corners[6];
    corners = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1, 16'sh5555, 16'shAAAA};
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = REG_IMAGE_WIDTH;
    cfg_data_i = '0;
    pix.valid  = 1'b0;
    pix.pixel  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one-pixel image: every word is its own last tile
    write_cfg(REG_IMAGE_WIDTH, CFG_W'(1));
    write_cfg(REG_IMAGE_HEIGHT, CFG_W'(1));
    foreach (corners[i]) send_pixel(corners[i]);
    settle();
    write_cfg(REG_IMAGE_WIDTH, '0);
    write_cfg(REG_IMAGE_HEIGHT, '0);
    send_pixel(16'sh1234);
    settle();

    // partial right and bottom tiles; unused slots must not restart the image
    write_cfg(REG_IMAGE_WIDTH, CFG_W'(9));
    write_cfg(REG_IMAGE_HEIGHT, CFG_W'(2));
    for (int i = 0; i < 5; i++) send_pixel(draw_pixel(DATA_RAILS, '0));
    settle();
    write_cfg(REG_SPARE_A, CFG_W'(3));
    write_cfg(REG_SPARE_B, '1);
    for (int i = 0; i < 13; i++) send_pixel(draw_pixel(DATA_RAILS, '0));
    settle();

    // full-width row through a clamping width value
    write_cfg(REG_IMAGE_WIDTH, '1);
    write_cfg(REG_IMAGE_HEIGHT, CFG_W'(1));
    stream_pixels(MAX_DIM, DATA_FULL, 1'b0);

    while (random_sent < RANDOM_PIXELS) random_phase();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.pending() > 0)
      $display("%0d tile words never arrived", board.pending());
    $display("covered %0d pixels over %0d image settings, %0d tile words, %0d closing tiles",
             pixels_sent, phases_run, board.words_checked, board.last_tiles);
    $display("peak deviation %0d, tile rows to %0d, tile columns to %0d, %0d errors",
             board.max_dev, board.max_row, board.max_col, board.errors + board.pending());
    if (board.errors == 0 && board.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
sv/tsd_pkg.sv
sv/tsd_if.sv
sv/tile_std_deviation_core.sv
sv/tsd_checker.sv
tb/testbench.sv
